@@ src/sorted_priority_queue_core_assert.svh @@
// ============================================================================
// Sorted priority queue core - assertion macros
// Shorthand for the concurrent checks used inside the queue RTL.
// ============================================================================
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/spq_pkg.sv @@
// ============================================================================
// Sorted priority queue - package
// Sizes, command codes and the structs passed between the cells.
// ============================================================================
package spq_pkg;

    localparam int CAPACITY       = 16;
    localparam int PRIORITY_WIDTH = 16;
    localparam int ELEMENT_WIDTH  = 16;
    localparam int COUNT_WIDTH    = $clog2(CAPACITY + 1);
    localparam int HEAD_WIDTH     = 17;
    localparam int OUT_COUNT_W    = 5;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // one slot of the queue
    typedef struct packed {
        logic                      valid;
        logic [PRIORITY_WIDTH-1:0] pri;
        logic [ELEMENT_WIDTH-1:0]  elem;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic                      fire;
        logic [1:0]                cmd;
        logic                      full;
        logic [PRIORITY_WIDTH-1:0] pri;
        logic [ELEMENT_WIDTH-1:0]  elem;
    } t_req;

    // ripple flags from a cell to the next one toward the tail
    typedef struct packed {
        logic keep;   // this slot stays ahead of a new entry
        logic hit;    // element matched here or in a slot before
    } t_link;

endpackage

@@ src/spq_cell.sv @@
// ============================================================================
// Sorted priority queue - cell
// One slot of the sorted row; shifts toward tail on insert, toward head on remove.
// ============================================================================
module spq_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spq_pkg::t_req   i_req,
    input  spq_pkg::t_entry i_left,      // slot nearer the head
    input  spq_pkg::t_link  i_link,      // flags from slot nearer the head
    input  spq_pkg::t_entry i_right,     // slot nearer the tail
    output spq_pkg::t_entry o_entry,
    output spq_pkg::t_link  o_link
);
    import spq_pkg::*;

    logic   r_valid;
    logic   n_valid;
    logic [PRIORITY_WIDTH-1:0] r_pri;
    logic [PRIORITY_WIDTH-1:0] n_pri;
    logic [ELEMENT_WIDTH-1:0]  r_elem;
    logic [ELEMENT_WIDTH-1:0]  n_elem;
    logic   w_keep;
    logic   w_match;

    assign w_keep  = r_valid && (r_pri >= i_req.pri);
    assign w_match = r_valid && (r_elem == i_req.elem);

    assign o_link.keep = w_keep;
    assign o_link.hit  = i_link.hit || w_match;

    assign o_entry.valid = r_valid;
    assign o_entry.pri   = r_pri;
    assign o_entry.elem  = r_elem;

    always_comb begin
        n_valid = r_valid;
        n_pri   = r_pri;
        n_elem  = r_elem;
        if (i_req.fire) begin
            case (i_req.cmd)
                CMD_INSERT: begin
                    if (!i_req.full && !w_keep) begin
                        if (i_link.keep) begin
                            n_valid = 1'b1;
                            n_pri   = i_req.pri;
                            n_elem  = i_req.elem;
                        end else begin
                            n_valid = i_left.valid;
                            n_pri   = i_left.pri;
                            n_elem  = i_left.elem;
                        end
                    end
                end
                CMD_REMOVE: begin
                    if (o_link.hit) begin
                        n_valid = i_right.valid;
                        n_pri   = i_right.pri;
                        n_elem  = i_right.elem;
                    end
                end
                CMD_LOOKUP: begin
                    n_valid = r_valid;
                end
                CMD_CLEAR: begin
                    n_valid = 1'b0;
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pri  <= n_pri;
        r_elem <= n_elem;
    end

endmodule

@@ src/sorted_priority_queue_core.sv @@
// ============================================================================
// Sorted priority queue core
// Bounded queue of (priority, element) words kept in descending priority order.
// ============================================================================
//
//  Channel   Dir  tdata fields (low bit up)                       tuser
//  --------  ---  ----------------------------------------------  -----
//  s (cmd)   in   priority_req[15:0], element[31:16]              cmd[1:0]
//  m (rsp)   out  found[0], full_drop[1], head_element[18:2],     -
//                 head_priority[35:19], entry_count[40:36],
//                 is_empty[41], zero pad[47:42]
//
//  - One command word per clock while responses drain; its response word is
//    valid the next cycle. All CAPACITY cells compare against the command in
//    parallel, so the whole row updates together whatever the occupancy.
//  - Reset (synchronous, active low) empties the queue; slot payloads keep
//    whatever they held, only the valid bits clear. No word is taken in reset.
//  - The response sits in an output register; a new command is taken while
//    that register is empty or being drained in the same cycle.
//  - The head and count in the response are read from the live state, which
//    only changes when the next command is accepted.
//
module sorted_priority_queue_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,    // priority_req[15:0], element[31:16]
    input  logic [1:0]  i_s_tuser,    // cmd[1:0]
    // response stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata     // found, full_drop, head_element,
                                      // head_priority, entry_count, is_empty
);
    import spq_pkg::*;

    `include "sorted_priority_queue_core_assert.svh"

    t_req                   w_req;
    t_entry                 w_entry [CAPACITY];
    t_link                  w_link  [CAPACITY];
    logic [CAPACITY-1:0]    w_valid;
    logic                   w_accept;
    logic                   w_full;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   r_valid;
    logic                   r_found;
    logic                   r_drop;
    logic [HEAD_WIDTH-1:0]  w_head_elem;
    logic [HEAD_WIDTH-1:0]  w_head_pri;

    // output register free or draining this cycle; closed during reset
    assign o_s_tready = i_rst_n && (!r_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count == COUNT_WIDTH'(CAPACITY));

    assign w_req.fire = w_accept;
    assign w_req.cmd  = i_s_tuser;
    assign w_req.full = w_full;
    assign w_req.pri  = i_s_tdata[PRIORITY_WIDTH-1:0];
    assign w_req.elem = i_s_tdata[PRIORITY_WIDTH +: ELEMENT_WIDTH];

    // cell row: index 0 is the head
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_entry w_left;
            t_link  w_lnk_in;
            t_entry w_right;

            if (g == 0) begin : g_head
                assign w_left         = '0;
                assign w_lnk_in.keep  = 1'b1;   // new entry lands here if slot 0 yields
                assign w_lnk_in.hit   = 1'b0;
            end else begin : g_mid
                assign w_left   = w_entry[g-1];
                assign w_lnk_in = w_link[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_right = '0;            // empty slot shifts in at the tail
            end else begin : g_body
                assign w_right = w_entry[g+1];
            end

            spq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_req   (w_req),
                .i_left  (w_left),
                .i_link  (w_lnk_in),
                .i_right (w_right),
                .o_entry (w_entry[g]),
                .o_link  (w_link[g])
            );

            assign w_valid[g] = w_entry[g].valid;
        end
    endgenerate

    // occupancy tracking
    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            case (w_req.cmd)
                CMD_INSERT: begin
                    if (!w_full) begin
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (w_link[CAPACITY-1].hit) begin
                        n_count = r_count - 1'b1;
                    end
                end
                CMD_LOOKUP: begin
                    n_count = r_count;
                end
                CMD_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // response flags, captured with the command
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_found <= ((w_req.cmd == CMD_REMOVE) || (w_req.cmd == CMD_LOOKUP))
                       && w_link[CAPACITY-1].hit;
            r_drop  <= (w_req.cmd == CMD_INSERT) && w_full;
        end
    end

    // head snapshot, all ones when empty
    assign w_head_elem = (r_count == '0) ? '1 : HEAD_WIDTH'(w_entry[0].elem);
    assign w_head_pri  = (r_count == '0) ? '1 : HEAD_WIDTH'(w_entry[0].pri);

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {6'd0,
                         (r_count == '0),
                         OUT_COUNT_W'(r_count),
                         w_head_pri,
                         w_head_elem,
                         r_drop,
                         r_found};

    // checks
    `SPQ_ASSERT_IMP(a_count_matches_cells, i_clk, i_rst_n, 1'b1,
                    $countones(w_valid) == 32'(r_count),
                    "occupancy differs from number of valid cells")
    `SPQ_ASSERT_IMP(a_valid_packed_at_head, i_clk, i_rst_n, 1'b1,
                    (w_valid & (w_valid + 1'b1)) == '0,
                    "valid cells not contiguous from head")
    `SPQ_ASSERT_NXT(a_clear_empties, i_clk, i_rst_n,
                    w_accept && (w_req.cmd == CMD_CLEAR), r_count == '0,
                    "clear left entries behind")
    `SPQ_ASSERT_NXT(a_full_insert_holds, i_clk, i_rst_n,
                    w_accept && (w_req.cmd == CMD_INSERT) && w_full,
                    $stable(w_valid) && r_drop,
                    "insert into full queue changed state")

endmodule

@@ sim/sorted_priority_queue_core_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Sorted priority queue core - testbench
// Drives insert, remove, lookup and clear command words into the queue,
// tracks a shadow copy of the sorted entries and checks every response
// word (found, drop flag, head, count, empty) in order of arrival.
// ============================================================================
module sorted_priority_queue_core_test;
    import spq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    // response word layout below the zero pad, is_empty in the top bit, found in bit 0
    typedef struct packed {
        logic                   is_empty;
        logic [OUT_COUNT_W-1:0] entry_count;
        logic [HEAD_WIDTH-1:0]  head_priority;
        logic [HEAD_WIDTH-1:0]  head_element;
        logic                   full_drop;
        logic                   found;
    } queue_snapshot_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;    // priority_req[15:0], element[31:16]
    logic [1:0]  i_s_tuser  = '0;    // cmd[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;          // found, full_drop, head_element,
                                     // head_priority, entry_count, is_empty

    // shadow of the queue contents, slot 0 is the head
    logic [PRIORITY_WIDTH-1:0] shadow_pri[CAPACITY];
    logic [ELEMENT_WIDTH-1:0]  shadow_elem[CAPACITY];
    int                        shadow_count = 0;

    queue_snapshot_t pending_snapshots[$];

    int mismatch_count = 0;
    int rsp_index      = 0;
    int cycle_count    = 0;
    bit tx_gaps        = 1'b1;
    bit rx_stalls      = 1'b1;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    sorted_priority_queue_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sorted_priority_queue_core test failed");
            $finish;
        end
    end

    // first slot holding elem, -1 when absent
    function automatic int find_elem(logic [ELEMENT_WIDTH-1:0] elem);
        for (int i = 0; i < shadow_count; i++)
            if (shadow_elem[i] == elem)
                return i;
        return -1;
    endfunction

    // apply one command to the shadow queue and return the response it owes
    function automatic queue_snapshot_t apply_queue_cmd(logic [1:0] cmd,
                                                        logic [PRIORITY_WIDTH-1:0] pri,
                                                        logic [ELEMENT_WIDTH-1:0] elem);
        queue_snapshot_t snap;
        int              pos;
        snap = '0;
        case (cmd)
            CMD_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    snap.full_drop = 1'b1;
                end else begin
                    // equal priorities keep arrival order: skip past them
                    pos = 0;
                    while (pos < shadow_count && shadow_pri[pos] >= pri)
                        pos++;
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_pri[i]  = shadow_pri[i-1];
                        shadow_elem[i] = shadow_elem[i-1];
                    end
                    shadow_pri[pos]  = pri;
                    shadow_elem[pos] = elem;
                    shadow_count++;
                end
            end
            CMD_REMOVE: begin
                pos = find_elem(elem);
                if (pos >= 0) begin
                    for (int i = pos; i + 1 < shadow_count; i++) begin
                        shadow_pri[i]  = shadow_pri[i+1];
                        shadow_elem[i] = shadow_elem[i+1];
                    end
                    shadow_count--;
                    snap.found = 1'b1;
                end
            end
            CMD_LOOKUP: begin
                snap.found = (find_elem(elem) >= 0);
            end
            default: begin
                shadow_count = 0;
            end
        endcase
        if (shadow_count == 0) begin
            snap.head_element  = '1;
            snap.head_priority = '1;
        end else begin
            snap.head_element  = HEAD_WIDTH'(shadow_elem[0]);
            snap.head_priority = HEAD_WIDTH'(shadow_pri[0]);
        end
        snap.entry_count = OUT_COUNT_W'(shadow_count);
        snap.is_empty    = (shadow_count == 0);
        return snap;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("response %0d %s: expected 0x%0h, got 0x%0h",
                         rsp_index, name, want, got);
        end
    endfunction

    // response side: random stalls, long hold-off on request, in-order check
    always @(posedge i_clk) begin : rsp_checker
        queue_snapshot_t want, got;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got = queue_snapshot_t'(o_m_tdata[41:0]);
                if (pending_snapshots.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("response %0d arrived with no command outstanding",
                                 rsp_index);
                end else begin
                    want = pending_snapshots.pop_front();
                    compare_field("found", 32'(want.found), 32'(got.found));
                    compare_field("full_drop", 32'(want.full_drop), 32'(got.full_drop));
                    compare_field("head_element", 32'(want.head_element),
                                  32'(got.head_element));
                    compare_field("head_priority", 32'(want.head_priority),
                                  32'(got.head_priority));
                    compare_field("entry_count", 32'(want.entry_count),
                                  32'(got.entry_count));
                    compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
                end
                rsp_index++;
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (rx_stalls) begin
                i_m_tready <= ($urandom_range(99) >= 37);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // offer one command word; tvalid stays up on return so a following
    // word can go out back to back
    task automatic push_command(logic [1:0] cmd, logic [PRIORITY_WIDTH-1:0] pri,
                                logic [ELEMENT_WIDTH-1:0] elem);
        while (tx_gaps && $urandom_range(99) < 37) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {elem, pri};
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        pending_snapshots.push_back(apply_queue_cmd(cmd, pri, elem));
    endtask

    task automatic wait_queue_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_snapshots.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic push_random_command();
        logic [1:0]                cmd;
        logic [PRIORITY_WIDTH-1:0] pri;
        logic [ELEMENT_WIDTH-1:0]  elem;
        int                        r;
        int                        insert_w;
        r        = $urandom_range(99);
        insert_w = (shadow_count < 12) ? 52 : 40;
        if (r < 3)
            cmd = CMD_CLEAR;
        else if (r < 3 + insert_w)
            cmd = CMD_INSERT;
        else if (r < 28 + insert_w)
            cmd = CMD_REMOVE;
        else
            cmd = CMD_LOOKUP;

        // small priority pool makes ties common
        r = $urandom_range(99);
        if (r < 50)
            pri = PRIORITY_WIDTH'($urandom_range(7));
        else if (r < 58)
            pri = '0;
        else if (r < 66)
            pri = '1;
        else
            pri = PRIORITY_WIDTH'($urandom);

        // remove and lookup mostly hit a stored element; inserts repeat often
        r = $urandom_range(99);
        if (cmd != CMD_INSERT && shadow_count > 0 && r < 60)
            elem = shadow_elem[$urandom_range(shadow_count - 1)];
        else if (r < 80)
            elem = ELEMENT_WIDTH'($urandom_range(15));
        else
            elem = ELEMENT_WIDTH'($urandom);
        push_command(cmd, pri, elem);
    endtask

    task automatic test_directed();
        push_command(CMD_LOOKUP, 16'h0000, 16'h0000);   // lookup on empty
        push_command(CMD_REMOVE, 16'h0000, 16'hFFFF);   // remove on empty
        push_command(CMD_CLEAR,  16'hFFFF, 16'h0000);   // clear on empty
        push_command(CMD_INSERT, 16'hFFFF, 16'hFFFF);
        push_command(CMD_INSERT, 16'h0000, 16'h0000);
        push_command(CMD_INSERT, 16'h8000, 16'h1234);
        push_command(CMD_INSERT, 16'h8000, 16'h5678);   // tie goes behind
        push_command(CMD_INSERT, 16'h8000, 16'h1234);   // duplicate element
        push_command(CMD_LOOKUP, 16'h0000, 16'h1234);
        push_command(CMD_REMOVE, 16'h0000, 16'h1234);   // head-most copy only
        push_command(CMD_REMOVE, 16'h0000, 16'hFFFF);   // head leaves
        push_command(CMD_REMOVE, 16'h0000, 16'hABCD);   // absent
        // fill to capacity, then one insert past full
        for (int i = 0; shadow_count < CAPACITY; i++)
            push_command(CMD_INSERT, (i % 3 == 0) ? 16'hFFFF : 16'(i * 16'h1111),
                         16'hA5A5 ^ 16'(i));
        push_command(CMD_INSERT, 16'h7FFF, 16'h5A5A);
        push_command(CMD_CLEAR,  16'h0000, 16'h0000);
    endtask

    task automatic test_random_traffic(int n);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        repeat (n) push_random_command();
    endtask

    task automatic test_no_idle(int n);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        repeat (n) push_random_command();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    // receiver holds off while commands keep coming, so the input stalls
    task automatic test_backpressure();
        tx_gaps = 1'b0;
        hold_req++;
        repeat (40) push_random_command();
        tx_gaps = 1'b1;
    endtask

    // sender stops until every response is back, several times
    task automatic test_drain_pause();
        repeat (6) begin
            repeat ($urandom_range(10, 30)) push_random_command();
            wait_queue_drained();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(600);
        test_no_idle(400);
        test_backpressure();
        test_drain_pause();
        test_random_traffic(600);

        wait_queue_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("sorted_priority_queue_core test passed");
        else
            $display("sorted_priority_queue_core test failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_core.sv
sim/sorted_priority_queue_core_test.sv
